// ===== hdl/wrr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wrr_pkg
// Types, codes and sizes shared by the watermark ring reservoir files.
// ----------------------------------------------------------------------------
package wrr_pkg;

    localparam int C_DEPTH     = 4096;
    localparam int C_IDX_W     = $clog2(C_DEPTH);
    localparam int C_CNT_W     = 13;
    localparam int C_LEVEL_W   = 16;
    localparam int C_BYTE_W    = 8;
    localparam int C_CFG_IDX_W = 1;

    localparam logic [C_LEVEL_W-1:0] C_HIGH_RESET = 16'd2048;
    localparam logic [C_LEVEL_W-1:0] C_LOW_RESET  = 16'd256;

    // command codes
    localparam logic [1:0] CMD_POLL = 2'd0;
    localparam logic [1:0] CMD_PUSH = 2'd1;
    localparam logic [1:0] CMD_POP  = 2'd2;
    localparam logic [1:0] CMD_NOP  = 2'd3;

    // poll decisions
    localparam logic [1:0] ACT_NONE  = 2'd0;
    localparam logic [1:0] ACT_FILL  = 2'd1;
    localparam logic [1:0] ACT_DRAIN = 2'd2;

    // status codes
    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_FULL  = 2'd1;
    localparam logic [1:0] STS_EMPTY = 2'd2;

    // configuration register indexes
    localparam logic [C_CFG_IDX_W-1:0] REG_HIGH_THRESH = 1'd0;
    localparam logic [C_CFG_IDX_W-1:0] REG_LOW_THRESH  = 1'd1;

    typedef struct packed {
        logic [1:0]           command;
        logic [C_LEVEL_W-1:0] pool_level;
        logic [C_BYTE_W-1:0]  data_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]          action;
        logic [C_CNT_W-1:0]  byte_count;
        logic [C_BYTE_W-1:0] data_out;
        logic [1:0]          status;
        logic [C_CNT_W-1:0]  occupancy;
    } t_out_item;

endpackage
`default_nettype wire

// ===== hdl/wrr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wrr_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ===== hdl/watermark_ring_reservoir_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// watermark_ring_reservoir_top
// Byte ring reservoir with fill and drain watermarks on a pool level.
// ----------------------------------------------------------------------------
// Usage:
//   A command is taken at a rising edge with start high and busy low. Push
//   stores a byte, pop returns the oldest byte, poll compares a pool level
//   against the high and low thresholds and reports a capped fill or drain.
//   Every command yields exactly one result, shown on o_res for one cycle
//   with o_res_valid high, in the cycle right after the transfer.
//   Throughput is one command per cycle: the byte store is a RAM with one
//   write and one registered read port, a push writes at its transfer edge
//   and a pop reads at its transfer edge, so busy never rises.
//   Thresholds are written through i_cfg_we / i_cfg_idx / i_cfg_data while
//   no command is in flight; they take effect for the next command.
//   Reset (synchronous, active low) empties the reservoir, zeroes both ring
//   indices and restores the thresholds to 2048 and 256 bits. The RAM is not
//   cleared; a pop never reaches an entry that was not pushed.
//   The receiver cannot stall: each result must be taken in its cycle.
// ----------------------------------------------------------------------------
module watermark_ring_reservoir_top
    import wrr_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire t_in_item               i_item,
    output logic                        o_res_valid,
    output t_out_item                   o_res,
    input  wire logic                   i_cfg_we,
    input  wire logic [C_CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [C_LEVEL_W-1:0]   i_cfg_data
);

    logic [C_LEVEL_W-1:0] r_high_thresh;
    logic [C_LEVEL_W-1:0] r_low_thresh;
    logic [C_IDX_W-1:0]   r_wr_idx, n_wr_idx;
    logic [C_IDX_W-1:0]   r_rd_idx, n_rd_idx;
    logic [C_CNT_W-1:0]   r_held, n_held;
    logic                 r_valid;
    logic                 r_pop_ok;
    t_out_item            r_res, n_res;

    logic                 accept;
    logic                 push_ok;
    logic                 pop_ok;
    logic [C_BYTE_W-1:0]  ram_rdata;

    // poll arithmetic
    logic [C_LEVEL_W-1:0] floor8;
    logic [C_LEVEL_W:0]   ceil8;
    logic [C_LEVEL_W-1:0] fill_diff;
    logic [C_LEVEL_W:0]   drain_diff;
    logic [C_CNT_W-1:0]   fill_raw;
    logic [C_CNT_W-1:0]   drain_raw;
    logic [C_CNT_W-1:0]   room;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign push_ok = (i_item.command == CMD_PUSH) && (r_held != C_CNT_W'(C_DEPTH));
    assign pop_ok  = (i_item.command == CMD_POP) && (r_held != '0);

    wrr_ram #(
        .WIDTH (C_BYTE_W),
        .DEPTH (C_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (accept && push_ok),
        .i_waddr (r_wr_idx),
        .i_wdata (i_item.data_in),
        .i_re    (accept && pop_ok),
        .i_raddr (r_rd_idx),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        floor8     = i_item.pool_level & ~C_LEVEL_W'(7);
        ceil8      = ({1'b0, i_item.pool_level} + (C_LEVEL_W + 1)'(7)) & ~(C_LEVEL_W + 1)'(7);
        fill_diff  = floor8 - r_high_thresh;
        drain_diff = {1'b0, r_low_thresh} - ceil8;
        fill_raw   = (floor8 > r_high_thresh) ? C_CNT_W'(fill_diff >> 3) : '0;
        drain_raw  = ({1'b0, r_low_thresh} > ceil8) ? C_CNT_W'(drain_diff >> 3) : '0;
        room       = C_CNT_W'(C_DEPTH) - r_held;
    end

    always_comb begin
        n_wr_idx = r_wr_idx;
        n_rd_idx = r_rd_idx;
        n_held   = r_held;
        n_res    = '0;

        unique case (i_item.command)
            CMD_POLL: begin
                priority if (i_item.pool_level >= r_high_thresh) begin
                    n_res.action     = ACT_FILL;
                    n_res.byte_count = (fill_raw > room) ? room : fill_raw;
                end else if (i_item.pool_level <= r_low_thresh) begin
                    n_res.action     = ACT_DRAIN;
                    n_res.byte_count = (drain_raw > r_held) ? r_held : drain_raw;
                end else begin
                    n_res.action = ACT_NONE;
                end
            end
            CMD_PUSH: begin
                if (push_ok) begin
                    n_wr_idx = (r_wr_idx == C_IDX_W'(C_DEPTH - 1)) ? '0 : r_wr_idx + 1'b1;
                    n_held   = r_held + 1'b1;
                end else begin
                    n_res.status = STS_FULL;
                end
            end
            CMD_POP: begin
                if (pop_ok) begin
                    n_rd_idx = (r_rd_idx == C_IDX_W'(C_DEPTH - 1)) ? '0 : r_rd_idx + 1'b1;
                    n_held   = r_held - 1'b1;
                end else begin
                    n_res.status = STS_EMPTY;
                end
            end
            CMD_NOP: begin
                n_res.action = ACT_NONE;
            end
            default: begin
                n_res.action = ACT_NONE;
            end
        endcase

        n_res.occupancy = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_thresh <= C_HIGH_RESET;
            r_low_thresh  <= C_LOW_RESET;
            r_wr_idx      <= '0;
            r_rd_idx      <= '0;
            r_held        <= '0;
            r_valid       <= 1'b0;
            r_pop_ok      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_HIGH_THRESH: r_high_thresh <= i_cfg_data;
                    REG_LOW_THRESH:  r_low_thresh  <= i_cfg_data;
                    default:         r_high_thresh <= r_high_thresh;
                endcase
            end
            r_valid  <= accept;
            r_pop_ok <= accept && pop_ok;
            if (accept) begin
                r_wr_idx <= n_wr_idx;
                r_rd_idx <= n_rd_idx;
                r_held   <= n_held;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= n_res;
        end
    end

    // popped byte arrives from the ram read register in the cycle after transfer
    always_comb begin
        o_res          = r_res;
        o_res.data_out = r_pop_ok ? ram_rdata : '0;
    end

    assign o_res_valid = r_valid;

endmodule
`default_nettype wire

// ===== hdl/wrr_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wrr_checker
// Port-level checks on the watermark ring reservoir, bound to the top level.
// ----------------------------------------------------------------------------
module wrr_checker
    import wrr_pkg::*;
(
    input wire logic                   i_clk,
    input wire logic                   i_rst_n,
    input wire logic                   start,
    input wire logic                   busy,
    input wire t_in_item               i_item,
    input wire logic                   o_res_valid,
    input wire t_out_item              o_res,
    input wire logic                   i_cfg_we,
    input wire logic [C_CFG_IDX_W-1:0] i_cfg_idx,
    input wire logic [C_LEVEL_W-1:0]   i_cfg_data
);

    // every transfer gives one result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_res_valid)
        else $error("no result after command transfer");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_res_valid)
        else $error("result without command transfer");

    // a fill or drain decision never carries a byte or a refusal
    a_poll_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.action != ACT_NONE))
            |-> (o_res.status == STS_OK) && (o_res.data_out == '0))
        else $error("poll result carries byte or status");

    // a refused push or pop moves nothing
    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.status != STS_OK))
            |-> (o_res.data_out == '0) && (o_res.byte_count == '0))
        else $error("refused command returns data");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> (o_res.occupancy <= C_CNT_W'(C_DEPTH)))
        else $error("occupancy beyond capacity");

    // unused inputs kept visible for the bind
    logic unused_cfg;
    assign unused_cfg = i_cfg_we ^ (|i_cfg_idx) ^ (|i_cfg_data) ^ (|i_item);

endmodule

bind watermark_ring_reservoir_top wrr_checker u_wrr_checker (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the watermark ring reservoir. Directed corner
// commands come first, then a push burst and a drain to empty with capped
// polls, then random command streams under several threshold settings.
// Every result is compared field by field with a shadow copy of the reservoir.
// ----------------------------------------------------------------------------
module tb_top;
    import wrr_pkg::*;

    localparam int C_CYCLE_LIMIT = 200000;
    localparam int C_DRAIN_LIMIT = 1000;

    // shadow of the reservoir plus the results it has promised
    class reservoir_shadow;
        logic [C_BYTE_W-1:0] ring [C_DEPTH];
        int unsigned wr_ptr;
        int unsigned rd_ptr;
        int unsigned held;
        int unsigned high_thr;
        int unsigned low_thr;
        t_out_item pending_results [$];
        int mismatches;

        function new();
            wr_ptr = 0;
            rd_ptr = 0;
            held = 0;
            high_thr = C_HIGH_RESET;
            low_thr = C_LOW_RESET;
            mismatches = 0;
        endfunction

        function void set_thresholds(input logic [15:0] high_v, input logic [15:0] low_v);
            high_thr = high_v;
            low_thr = low_v;
        endfunction

        task report_mismatch(input string what);
            mismatches++;
            $display("%0t ns  mismatch: %s", $time, what);
        endtask

        // work out the result of one accepted command and queue it
        function void note_command(input t_in_item it);
            t_out_item res;
            int unsigned lvl;
            int unsigned rounded;
            int unsigned cnt;
            res = '0;
            lvl = it.pool_level;
            cnt = 0;
            case (it.command)
                CMD_POLL: begin
                    if (lvl >= high_thr) begin
                        rounded = lvl & ~32'd7;
                        res.action = ACT_FILL;
                        cnt = (rounded > high_thr) ? (rounded - high_thr) / 8 : 0;
                        if (cnt > C_DEPTH - held)
                            cnt = C_DEPTH - held;
                    end else if (lvl <= low_thr) begin
                        rounded = (lvl + 7) & ~32'd7;
                        res.action = ACT_DRAIN;
                        cnt = (low_thr > rounded) ? (low_thr - rounded) / 8 : 0;
                        if (cnt > held)
                            cnt = held;
                    end
                    res.byte_count = cnt[C_CNT_W-1:0];
                end
                CMD_PUSH: begin
                    if (held >= C_DEPTH) begin
                        res.status = STS_FULL;
                    end else begin
                        ring[wr_ptr] = it.data_in;
                        wr_ptr = (wr_ptr + 1 >= C_DEPTH) ? 0 : wr_ptr + 1;
                        held++;
                    end
                end
                CMD_POP: begin
                    if (held == 0) begin
                        res.status = STS_EMPTY;
                    end else begin
                        res.data_out = ring[rd_ptr];
                        rd_ptr = (rd_ptr + 1 >= C_DEPTH) ? 0 : rd_ptr + 1;
                        held--;
                    end
                end
                default: ;
            endcase
            res.occupancy = held[C_CNT_W-1:0];
            pending_results.push_back(res);
        endfunction

        task compare_field(input string name, input logic [15:0] got_v,
                           input logic [15:0] want_v);
            if (got_v !== want_v)
                report_mismatch($sformatf("%s got %0h expected %0h", name, got_v, want_v));
        endtask

        task check_result(input t_out_item got);
            t_out_item want;
            if (pending_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", got));
                return;
            end
            want = pending_results.pop_front();
            compare_field("action", 16'(got.action), 16'(want.action));
            compare_field("byte_count", 16'(got.byte_count), 16'(want.byte_count));
            compare_field("data_out", 16'(got.data_out), 16'(want.data_out));
            compare_field("status", 16'(got.status), 16'(want.status));
            compare_field("occupancy", 16'(got.occupancy), 16'(want.occupancy));
        endtask

        task report_leftovers();
            if (pending_results.size() != 0)
                report_mismatch($sformatf("%0d results never arrived",
                                          pending_results.size()));
        endtask
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    t_in_item               i_item;
    logic                   o_res_valid;
    t_out_item              o_res;
    logic                   i_cfg_we;
    logic [C_CFG_IDX_W-1:0] i_cfg_idx;
    logic [C_LEVEL_W-1:0]   i_cfg_data;

    reservoir_shadow shadow = new();
    int unsigned cycle_count = 0;
    int sender_idle_pct;
    int unsigned cur_high;
    int unsigned cur_low;

    watermark_ring_reservoir_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_item      (i_item),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= C_CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // values seen here are the ones the edge samples
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy)
                shadow.note_command(i_item);
            if (o_res_valid)
                shadow.check_result(o_res);
        end
    end

    task automatic send_command(input logic [1:0] cmd, input logic [15:0] level,
                                input logic [7:0] data);
        t_in_item it;
        it.command = cmd;
        it.pool_level = level;
        it.data_in = data;
        start <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (busy);
        if (sender_idle_pct > 0 && $urandom_range(0, 99) < sender_idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // stop sending and let every outstanding transfer come back
    task automatic wait_drain();
        int waited;
        waited = 0;
        start <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (shadow.pending_results.size() != 0 && waited < C_DRAIN_LIMIT);
        repeat (2) @(posedge i_clk);
    endtask

    task automatic write_thresholds(input logic [15:0] high_v, input logic [15:0] low_v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_HIGH_THRESH;
        i_cfg_data <= high_v;
        @(posedge i_clk);
        i_cfg_idx <= REG_LOW_THRESH;
        i_cfg_data <= low_v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        shadow.set_thresholds(high_v, low_v);
        cur_high = high_v;
        cur_low = low_v;
    endtask

    function automatic logic [15:0] pick_level();
        case ($urandom_range(0, 5))
            0: return 16'(cur_high + $urandom_range(0, 24) - 8);
            1: return 16'(cur_low + $urandom_range(0, 24) - 16);
            2: return 16'($urandom_range(0, 63));
            3: return 16'hFFFF - 16'($urandom_range(0, 63));
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [15:0] pick_threshold();
        case ($urandom_range(0, 3))
            0: return 16'($urandom_range(1, 8191) * 8);
            1: return 16'($urandom_range(0, 65535));
            2: return 16'd8;
            default: return 16'd65528;
        endcase
    endfunction

    task automatic send_random_command();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            send_command(CMD_POLL, pick_level(), 8'($urandom));
        else if (pick < 62)
            send_command(CMD_PUSH, 16'($urandom), 8'($urandom));
        else if (pick < 95)
            send_command(CMD_POP, 16'($urandom), 8'($urandom));
        else
            send_command(CMD_NOP, 16'($urandom), 8'($urandom));
    endtask

    // runs of mixed traffic, push bursts, pop bursts and poll bursts, with an occasional drain
    task automatic run_random(input int n_items);
        int sent;
        int kind;
        int len;
        sent = 0;
        while (sent < n_items) begin
            kind = $urandom_range(0, 19);
            len = $urandom_range(4, 30);
            if (kind == 19) begin
                wait_drain();
                len = 0;
            end
            for (int k = 0; k < len; k++) begin
                if (kind < 8)
                    send_random_command();
                else if (kind < 12)
                    send_command(CMD_PUSH, 16'($urandom), 8'($urandom));
                else if (kind < 16)
                    send_command(CMD_POP, 16'($urandom), 8'($urandom));
                else
                    send_command(CMD_POLL, pick_level(), 8'($urandom));
            end
            sent += len;
        end
    endtask

    initial begin
        start <= 1'b0;
        i_item <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_idx <= '0;
        i_cfg_data <= '0;
        i_rst_n <= 1'b0;
        sender_idle_pct = 8;
        cur_high = C_HIGH_RESET;
        cur_low = C_LOW_RESET;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners under the reset thresholds
        send_command(CMD_POP, 16'h0000, 8'h00);
        send_command(CMD_POLL, 16'h0000, 8'hFF);
        send_command(CMD_POLL, 16'hFFFF, 8'h00);
        send_command(CMD_POLL, 16'd2048, 8'h00);
        send_command(CMD_POLL, 16'd2047, 8'h00);
        send_command(CMD_POLL, 16'd256, 8'h00);
        send_command(CMD_NOP, 16'hFFFF, 8'hFF);
        send_command(CMD_PUSH, 16'hFFFF, 8'h00);
        send_command(CMD_PUSH, 16'h0000, 8'hFF);
        send_command(CMD_PUSH, 16'h1234, 8'h5A);
        send_command(CMD_POLL, 16'd200, 8'h00);
        send_command(CMD_POLL, 16'd0, 8'h00);
        send_command(CMD_POLL, 16'd2055, 8'h00);
        send_command(CMD_POLL, 16'd2056, 8'h00);
        repeat (4) send_command(CMD_POP, 16'h0000, 8'h00);
        send_command(CMD_NOP, 16'h0000, 8'h00);
        wait_drain();

        // thresholds off the multiple of eight
        write_thresholds(16'hFFFF, 16'd7);
        send_command(CMD_POLL, 16'hFFFF, 8'h00);
        send_command(CMD_POLL, 16'd7, 8'h00);
        send_command(CMD_POLL, 16'd0, 8'h00);
        wait_drain();

        // both watermarks hit, fill wins
        write_thresholds(16'd8, 16'd8);
        send_command(CMD_POLL, 16'd8, 8'h00);
        send_command(CMD_POLL, 16'd16, 8'h00);
        send_command(CMD_POLL, 16'd7, 8'h00);
        wait_drain();

        // push burst and drain to empty, fill capped by room, drain by held bytes
        sender_idle_pct = 0;
        write_thresholds(16'd8, 16'd65528);
        send_command(CMD_POLL, 16'hFFFF, 8'h00);
        send_command(CMD_POLL, 16'h0000, 8'h00);
        repeat (40) send_command(CMD_PUSH, 16'($urandom), 8'($urandom));
        send_command(CMD_POLL, 16'hFFFF, 8'h00);
        send_command(CMD_POLL, 16'h0000, 8'h00);
        repeat (44) send_command(CMD_POP, 16'($urandom), 8'($urandom));
        wait_drain();

        // random traffic: sender gaps rare, then frequent, then none
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 73 : 0;
            write_thresholds(pick_threshold(), pick_threshold());
            run_random(100);
            wait_drain();
        end

        shadow.report_leftovers();
        if (shadow.mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
